// ----- hw/rtl/mail_header_to_rewriter_defines.svh -----
// Assertion helpers for the top-level RTL file.
// Each macro expects clk and rst_n in scope.
`ifndef MAIL_HEADER_TO_REWRITER_DEFINES_SVH
`define MAIL_HEADER_TO_REWRITER_DEFINES_SVH

// Same-cycle implication.
`define MHTR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MHTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mhtr_pkg.sv -----
`default_nettype none

package mhtr_pkg;

  localparam int unsigned MaxRes = 3;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChUpT   = 8'h54;
  localparam logic [7:0] ChLowT  = 8'h74;
  localparam logic [7:0] ChLowO  = 8'h6F;
  localparam logic [7:0] ChUpO   = 8'h4F;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_MARK   = 2'd1,
    KIND_OK     = 2'd2,
    KIND_NOBODY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_UNDECIDED = 2'd0,
    MODE_PASS      = 2'd1,
    MODE_DROP      = 2'd2,
    MODE_REPLACE   = 2'd3
  } mode_t;

  typedef struct packed {
    logic            in_body;
    logic            seen_to;
    logic            after_to;
    mode_t           mode;
    logic [1:0]      held_cnt;
    logic [1:0][7:0] held;
  } st_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] res;
    logic [1:0]        cnt;
  } bundle_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mhtr_decide.sv -----
`default_nettype none

// Per-word decision: next state and the list of results for one input word.
module mhtr_decide (
  input  var mhtr_pkg::st_t     st,
  input  var logic [7:0]        in_byte,
  input  var logic              in_end_of_message,
  output var mhtr_pkg::st_t     st_nxt,
  output var mhtr_pkg::bundle_t bnd
);

  function automatic mhtr_pkg::res_t mk_byte(logic [7:0] b);
    mhtr_pkg::res_t r;
    r.kind = mhtr_pkg::KIND_BYTE;
    r.data = b;
    return r;
  endfunction

  function automatic mhtr_pkg::res_t mk_kind(mhtr_pkg::kind_t k);
    mhtr_pkg::res_t r;
    r.kind = k;
    r.data = 8'h00;
    return r;
  endfunction

  // Flush held line-start bytes, then append one result.
  function automatic mhtr_pkg::bundle_t held_then(mhtr_pkg::st_t s, mhtr_pkg::res_t tail);
    mhtr_pkg::bundle_t b;
    b = '0;
    case (s.held_cnt)
      2'd1: begin
        b.res[0] = mk_byte(s.held[0]);
        b.res[1] = tail;
        b.cnt    = 2'd2;
      end
      2'd2: begin
        b.res[0] = mk_byte(s.held[0]);
        b.res[1] = mk_byte(s.held[1]);
        b.res[2] = tail;
        b.cnt    = 2'd3;
      end
      default: begin
        b.res[0] = tail;
        b.cnt    = 2'd1;
      end
    endcase
    return b;
  endfunction

  logic is_blank;
  logic is_t;
  logic is_o;

  assign is_blank = (in_byte == mhtr_pkg::ChSpace) || (in_byte == mhtr_pkg::ChTab);
  assign is_t     = (in_byte == mhtr_pkg::ChUpT) || (in_byte == mhtr_pkg::ChLowT);
  assign is_o     = (in_byte == mhtr_pkg::ChLowO) || (in_byte == mhtr_pkg::ChUpO);

  always_comb begin
    st_nxt = st;
    bnd    = '0;
    if (in_end_of_message) begin
      bnd.res[0] = mk_kind(st.in_body ? mhtr_pkg::KIND_OK : mhtr_pkg::KIND_NOBODY);
      bnd.cnt    = 2'd1;
      st_nxt     = '0;
    end else if (st.in_body) begin
      bnd.res[0] = mk_byte(in_byte);
      bnd.cnt    = 2'd1;
    end else if (in_byte == mhtr_pkg::ChNul) begin
      // drop NUL in the header
    end else if (in_byte == mhtr_pkg::ChNl) begin
      st_nxt.mode     = mhtr_pkg::MODE_UNDECIDED;
      st_nxt.held_cnt = 2'd0;
      unique case (st.mode)
        mhtr_pkg::MODE_UNDECIDED, mhtr_pkg::MODE_PASS: begin
          if (st.mode == mhtr_pkg::MODE_UNDECIDED && st.held_cnt == 2'd0) begin
            // blank line: header ends
            if (!st.seen_to) begin
              bnd.res[0] = mk_kind(mhtr_pkg::KIND_MARK);
              bnd.res[1] = mk_byte(mhtr_pkg::ChNl);
              bnd.cnt    = 2'd2;
            end else begin
              bnd.res[0] = mk_byte(mhtr_pkg::ChNl);
              bnd.cnt    = 2'd1;
            end
            st_nxt.in_body = 1'b1;
          end else begin
            bnd             = held_then(st, mk_byte(mhtr_pkg::ChNl));
            st_nxt.after_to = 1'b0;
          end
        end
        mhtr_pkg::MODE_REPLACE: begin
          bnd.res[0]      = mk_kind(mhtr_pkg::KIND_MARK);
          bnd.cnt         = 2'd1;
          st_nxt.seen_to  = 1'b1;
          st_nxt.after_to = 1'b1;
        end
        default: begin
          st_nxt.after_to = 1'b1;
        end
      endcase
    end else if (st.mode == mhtr_pkg::MODE_PASS) begin
      bnd.res[0] = mk_byte(in_byte);
      bnd.cnt    = 2'd1;
    end else if (st.mode == mhtr_pkg::MODE_UNDECIDED) begin
      case (st.held_cnt)
        2'd0: begin
          if (st.after_to && is_blank) begin
            st_nxt.mode = mhtr_pkg::MODE_DROP;
          end else if (is_t) begin
            st_nxt.held[0]  = in_byte;
            st_nxt.held_cnt = 2'd1;
          end else begin
            st_nxt.mode = mhtr_pkg::MODE_PASS;
            bnd.res[0]  = mk_byte(in_byte);
            bnd.cnt     = 2'd1;
          end
        end
        2'd1: begin
          if (is_o) begin
            st_nxt.held[1]  = in_byte;
            st_nxt.held_cnt = 2'd2;
          end else begin
            st_nxt.mode     = mhtr_pkg::MODE_PASS;
            st_nxt.held_cnt = 2'd0;
            bnd             = held_then(st, mk_byte(in_byte));
          end
        end
        default: begin
          st_nxt.held_cnt = 2'd0;
          if (in_byte == mhtr_pkg::ChColon) begin
            st_nxt.mode = st.seen_to ? mhtr_pkg::MODE_DROP : mhtr_pkg::MODE_REPLACE;
          end else begin
            st_nxt.mode = mhtr_pkg::MODE_PASS;
            bnd         = held_then(st, mk_byte(in_byte));
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mail_header_to_rewriter.sv -----
// Channel   Direction  Handshake           Word payload
// in_       in         in_valid/in_stall   in_byte, in_end_of_message
// out_      out        out_valid/out_stall out_kind, out_byte, out_last
//
// One input word is taken per cycle while out_stall is low and each word makes
// one result or none; a word that makes two or three results holds the input
// until the last of them leaves the single result bundle register, which the
// output drains one word a cycle.
// Reset (rst_n low, synchronous) clears the header state and empties the
// result bundle. out_stall stops the drain; a new word is taken in the same
// cycle the last result of the bundle leaves.
`default_nettype none

module mail_header_to_rewriter (
  input  var logic       clk,
  input  var logic       rst_n,
  input  var logic       in_valid,
  output var logic       in_stall,
  input  var logic [7:0] in_byte,
  input  var logic       in_end_of_message,
  output var logic       out_valid,
  input  var logic       out_stall,
  output var logic [1:0] out_kind,
  output var logic [7:0] out_byte,
  output var logic       out_last
);

  `include "mail_header_to_rewriter_defines.svh"

  // Header parse state.
  mhtr_pkg::st_t     st_r;
  mhtr_pkg::st_t     st_nxt;

  // Result bundle of the word in flight, drained one entry per cycle while out_stall is low.
  mhtr_pkg::bundle_t bnd_nxt;
  mhtr_pkg::res_t [mhtr_pkg::MaxRes-1:0] res_r;
  logic [1:0]        cnt_r;
  logic [1:0]        idx_r;
  logic              busy_r;

  logic              is_last;
  logic              drain;
  logic              finish;
  logic              in_acc;

  mhtr_decide u_decide (
    .st                (st_r),
    .in_byte           (in_byte),
    .in_end_of_message (in_end_of_message),
    .st_nxt            (st_nxt),
    .bnd               (bnd_nxt)
  );

  // Present the current bundle entry.
  assign is_last   = (idx_r == (cnt_r - 2'd1));
  assign out_valid = busy_r;
  assign out_kind  = res_r[idx_r].kind;
  assign out_byte  = res_r[idx_r].data;
  assign out_last  = is_last;

  // Take a new word once the bundle is empty or its final entry leaves now.
  assign drain    = busy_r && !out_stall;
  assign finish   = drain && is_last;
  assign in_stall = busy_r && !finish;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      busy_r <= 1'b0;
      cnt_r  <= 2'd0;
      idx_r  <= 2'd0;
    end else begin
      if (in_acc) begin
        // advance the header state on every accepted word
        st_r <= st_nxt;
      end
      if (in_acc && (bnd_nxt.cnt != 2'd0)) begin
        // load a fresh bundle
        busy_r <= 1'b1;
        cnt_r  <= bnd_nxt.cnt;
        idx_r  <= 2'd0;
      end else if (finish) begin
        busy_r <= 1'b0;
        idx_r  <= 2'd0;
      end else if (drain) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  // Bundle payload: no reset needed.
  always_ff @(posedge clk) begin
    if (in_acc && (bnd_nxt.cnt != 2'd0)) begin
      res_r <= bnd_nxt.res;
    end
  end

  `MHTR_ASSERT_NOW(a_idx_in_range, busy_r, (cnt_r != 2'd0) && (idx_r < cnt_r), "result index past bundle count")
  `MHTR_ASSERT_NOW(a_body_clean, st_r.in_body, (st_r.mode == mhtr_pkg::MODE_UNDECIDED) && (st_r.held_cnt == 2'd0), "held state left over in body")
  `MHTR_ASSERT_NOW(a_nonbyte_zero, out_valid && (out_kind != mhtr_pkg::KIND_BYTE), out_byte == 8'h00, "byte field not zero on marker or end word")
  `MHTR_ASSERT_NEXT(a_eom_resets, in_acc && in_end_of_message, !st_r.in_body && !st_r.seen_to && (st_r.held_cnt == 2'd0), "state not cleared after end word")

endmodule

`default_nettype wire

// ----- verif/tb_mail_header_to_rewriter.sv -----
`timescale 1ns / 100ps

// Stream mail messages into the header rewriter and compare every result word against
// an in-bench prediction of the To-line replacement. Directed messages hit the corner
// cases first, then random well-formed messages, raw noise and a burst with no idling.
module tb_mail_header_to_rewriter;
  import mhtr_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 20;

  // One expected result word.
  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } out_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_message = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;

  mail_header_to_rewriter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_byte          (out_byte),
    .out_last          (out_last)
  );

  // Free-running clock, 10 ns period.
  always #5 clk = ~clk;

  // Predicted header state, mirrored word by word.
  logic       hdr_in_body;
  logic       hdr_seen_to;
  logic       hdr_after_to;
  mode_t      hdr_mode;
  logic [1:0] hdr_held_cnt;
  logic [7:0] hdr_held [2];

  out_word_t  staged_words [$];   // results of the word being predicted
  out_word_t  rewritten_q [$];    // results still owed by the block

  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int unsigned messages_sent = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  bit          no_idle = 1'b0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_header_state();
    hdr_in_body  = 1'b0;
    hdr_seen_to  = 1'b0;
    hdr_after_to = 1'b0;
    hdr_mode     = MODE_UNDECIDED;
    hdr_held_cnt = 2'd0;
    hdr_held[0]  = 8'h00;
    hdr_held[1]  = 8'h00;
  endfunction

  function automatic void stage(kind_t k, logic [7:0] b);
    out_word_t w;
    w.kind = k;
    w.data = (k == KIND_BYTE) ? b : 8'h00;
    w.last = 1'b0;
    staged_words.push_back(w);
  endfunction

  // Release the held line-start bytes as ordinary bytes.
  function automatic void release_held();
    for (int i = 0; i < hdr_held_cnt; i++) stage(KIND_BYTE, hdr_held[i]);
    hdr_held_cnt = 2'd0;
  endfunction

  function automatic void close_header_line();
    if (hdr_mode == MODE_UNDECIDED && hdr_held_cnt == 2'd0) begin
      // Blank line: header ends, marker first if no To line came.
      if (!hdr_seen_to) stage(KIND_MARK, 8'h00);
      stage(KIND_BYTE, ChNl);
      hdr_in_body = 1'b1;
    end else if (hdr_mode == MODE_UNDECIDED || hdr_mode == MODE_PASS) begin
      release_held();
      stage(KIND_BYTE, ChNl);
      hdr_after_to = 1'b0;
    end else if (hdr_mode == MODE_REPLACE) begin
      stage(KIND_MARK, 8'h00);
      hdr_seen_to  = 1'b1;
      hdr_after_to = 1'b1;
    end else begin
      hdr_after_to = 1'b1;
    end
    hdr_mode     = MODE_UNDECIDED;
    hdr_held_cnt = 2'd0;
  endfunction

  function automatic void classify_header_byte(logic [7:0] b);
    if (hdr_mode == MODE_PASS) begin
      stage(KIND_BYTE, b);
    end else if (hdr_mode == MODE_UNDECIDED) begin
      if (hdr_held_cnt == 2'd0) begin
        if (hdr_after_to && (b == ChSpace || b == ChTab)) begin
          hdr_mode = MODE_DROP;
        end else if (b == ChUpT || b == ChLowT) begin
          hdr_held[0]  = b;
          hdr_held_cnt = 2'd1;
        end else begin
          hdr_mode = MODE_PASS;
          stage(KIND_BYTE, b);
        end
      end else if (hdr_held_cnt == 2'd1) begin
        if (b == ChLowO || b == ChUpO) begin
          hdr_held[1]  = b;
          hdr_held_cnt = 2'd2;
        end else begin
          hdr_mode = MODE_PASS;
          release_held();
          stage(KIND_BYTE, b);
        end
      end else begin
        if (b == ChColon) begin
          hdr_mode     = hdr_seen_to ? MODE_DROP : MODE_REPLACE;
          hdr_held_cnt = 2'd0;
        end else begin
          hdr_mode = MODE_PASS;
          release_held();
          stage(KIND_BYTE, b);
        end
      end
    end
  endfunction

  // Work out every result of one accepted word and queue them in order.
  function automatic void predict_rewrite(logic [7:0] b, logic eom);
    staged_words.delete();
    if (eom) begin
      stage(hdr_in_body ? KIND_OK : KIND_NOBODY, 8'h00);
      clear_header_state();
    end else if (hdr_in_body) begin
      stage(KIND_BYTE, b);
    end else if (b == ChNul) begin
      // NUL in the header: drop it, state unchanged.
    end else if (b == ChNl) begin
      close_header_line();
    end else begin
      classify_header_byte(b);
    end
    if (staged_words.size() > 0) staged_words[$].last = 1'b1;
    foreach (staged_words[i]) rewritten_q.push_back(staged_words[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------------

  // Send one word: idle a random gap, present it, hold until accepted.
  // Acceptance is sampled at the falling edge, where every signal is settled.
  task automatic send_word(input logic [7:0] b, input logic eom);
    int  gap;
    bit  took;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_byte           <= b;
    in_end_of_message <= eom;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    predict_rewrite(b, eom);
    words_sent++;
    if (eom) messages_sent++;
  endtask

  // End item; the byte field carries junk that must be ignored.
  task automatic send_end();
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Random header text, never a newline.
  task automatic send_text(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == ChNl) b = 8'h7E;
      send_word(b, 1'b0);
    end
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, then field-by-field check
  // ---------------------------------------------------------------------------

  // Draw a stall length per result word, then release until a word leaves.
  initial begin : result_stall
    int n;
    bit got;
    @(posedge rst_n);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        got = out_valid;
        @(posedge clk);
      end while (!got);
    end
  end

  // A word moves at the next rising edge when valid is high and stall low;
  // check it at the falling edge before, where both sides are settled.
  always @(negedge clk) begin
    out_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (rewritten_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: kind %0d byte %02h last %0b",
                   out_kind, out_byte, out_last);
      end else begin
        w = rewritten_q.pop_front();
        if (out_kind !== w.kind || out_byte !== w.data || out_last !== w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at word %0d: expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
                     results_checked, w.kind, w.data, w.last, out_kind, out_byte, out_last);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Lowercase t with uppercase O, tab continuation, a later To line dropped,
  // blank line right after the dropped line, then body with extreme bytes.
  task automatic test_to_replacement();
    send_string("tO:x\n\tq\nTo:\n\n");
    send_word(8'hFF, 1'b0);
    send_word(ChNul, 1'b0);
    send_end();
  endtask

  // Blank line as the very first byte: marker, newline, then end ok.
  task automatic test_blank_at_start();
    send_word(ChNl, 1'b0);
    send_end();
  endtask

  // NUL in the header, a one-byte short line, then an unfinished "To" whose
  // held bytes are thrown away at the end item.
  task automatic test_partial_header();
    send_word(ChNul, 1'b0);
    send_string("T\nTo");
    send_end();
  endtask

  // One random message built from typical header lines.
  task automatic send_message();
    int lines;
    int ending;
    lines = $urandom_range(0, 5);
    for (int l = 0; l < lines; l++) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          send_word($urandom_range(0, 1) ? ChUpT : ChLowT, 1'b0);
          send_word($urandom_range(0, 1) ? ChUpO : ChLowO, 1'b0);
          send_word(ChColon, 1'b0);
          send_text($urandom_range(0, 4));
          send_word(ChNl, 1'b0);
        end
        2: begin
          send_word($urandom_range(0, 1) ? ChSpace : ChTab, 1'b0);
          send_text($urandom_range(0, 3));
          send_word(ChNl, 1'b0);
        end
        3: begin
          // Starts like a To line, then breaks off.
          send_word(ChUpT, 1'b0);
          if ($urandom_range(0, 1)) send_word(ChLowO, 1'b0);
          send_text($urandom_range(1, 3));
          send_word(ChNl, 1'b0);
        end
        4: begin
          send_text($urandom_range(1, 2));
          send_word(ChNl, 1'b0);
        end
        default: begin
          send_text($urandom_range(1, 5));
          send_word(ChNl, 1'b0);
        end
      endcase
    end
    ending = $urandom_range(0, 9);
    if (ending <= 6) begin
      send_word(ChNl, 1'b0);
      for (int i = $urandom_range(0, 8); i > 0; i--)
        send_word(8'($urandom_range(0, 255)), 1'b0);
    end else if (ending <= 8) begin
      // Unfinished header line.
      if ($urandom_range(0, 1)) begin
        send_word(ChLowT, 1'b0);
        if ($urandom_range(0, 1)) send_word(ChUpO, 1'b0);
      end else begin
        send_text($urandom_range(1, 2));
      end
    end
    send_end();
  endtask

  task automatic test_random_messages(input int n_words);
    int unsigned stop_at;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) send_message();
  endtask

  // Raw bytes weighted toward the characters that steer the line decision.
  task automatic test_noise(input int n_words);
    logic [7:0] b;
    for (int i = 0; i < n_words; i++) begin
      case ($urandom_range(0, 9))
        0: b = ChUpT;
        1: b = ChLowO;
        2: b = ChColon;
        3: b = ChNl;
        4: b = $urandom_range(0, 1) ? ChSpace : ChTab;
        5: b = ChNul;
        default: b = 8'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 19) == 0) send_end();
      else send_word(b, 1'b0);
    end
    send_end();
  endtask

  // Full rate on both sides.
  task automatic test_burst(input int n_words);
    no_idle = 1'b1;
    test_random_messages(n_words);
    no_idle = 1'b0;
  endtask

  initial begin
    clear_header_state();
    // Hold reset low at the start, then release it once.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_to_replacement();
    test_blank_at_start();
    test_partial_header();
    test_random_messages(140);
    test_noise(40);
    test_burst(40);

    // Drop valid and drain everything still owed.
    in_valid <= 1'b0;
    while (rewritten_q.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d input words over %0d messages (directed, random, noise, burst).",
             words_sent, messages_sent);
    $display("Checked %0d result words, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0 && rewritten_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
